/* design/peg_pkg.sv */
// shared types, constants and weight table function for the pulse envelope generator
`default_nettype none
package peg_pkg;

  localparam int TABLE_DEPTH  = 512;
  localparam int HALF_DEPTH   = TABLE_DEPTH / 2;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int HIDX_W       = $clog2(HALF_DEPTH);
  localparam int TICK_W       = 20;
  localparam int DVD_W        = TICK_W + IDX_W;
  localparam int CNT_W        = $clog2(DVD_W + 1);
  localparam logic [31:0] MIN_EDGE_GAP = 32'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [IDX_W-1:0] TABLE_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_LEVEL = 3'd3,
    OP_EDGE  = 3'd4,
    OP_DRAIN = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    REG_BASELINE = 3'd0,
    REG_PEAK     = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_INTERVAL = 3'd3,
    REG_COUNT    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROM,
    ST_MUL,
    ST_FIN
  } state_t;

  // one truncated taylor term step, divisor picked per term
  function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
    longint unsigned r;
    r = 0;
    case (n)
      1: r = v / 6;
      2: r = v / 20;
      3: r = v / 42;
      4: r = v / 72;
      5: r = v / 110;
      6: r = v / 156;
      7: r = v / 210;
      8: r = v / 272;
      default: r = v / 342;
    endcase
    return r;
  endfunction

  // q0.16 weight for folded index k, sin^2 via q30 taylor series
  function automatic logic [15:0] weight_of(input int k);
    longint unsigned x, x2, term, pos, neg, s, w;
    x    = (64'd3373259426 * longint'(k)) / (TABLE_DEPTH - 1);
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 0;
    for (int n = 1; n <= 9; n++) begin
      term = taylor_div((term * x2) >> 30, n);
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    if (s > 64'd1073741824) s = 64'd1073741824;
    w = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'd65535) w = 64'd65535;
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

/* design/pulse_envelope_generator_core.sv */
// Pulse envelope generator top: registers, sequencer and result stage.
// Results: a tick inside a pass passes through divider start, the serial index divider,
// the index register, rom read, multiply and the output register; other items load it directly.
// Throughput: one item at a time; next item taken once the result is transferred,
// so a tick inside a pass holds off the input until its result has gone out.
// Reset: synchronous active-high rst clears run, pass and marker state and
// loads the configuration registers with their default values.
`default_nettype none
module pulse_envelope_generator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] now_us,
  input  wire logic [7:0]  level_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       dac_value,
  output logic             dac_driven,
  output logic             run_active,
  output logic [15:0]      passes_done,
  output logic             pass_ended,
  output logic [7:0]       pass_peak,
  output logic             marker_ready,
  output logic [31:0]      marker_start_us,
  output logic [31:0]      latency_us,
  output logic [15:0]      dropped_edges,
  output logic             run_done
);
  import peg_pkg::*;

  // configuration registers
  logic [7:0]  baseline, peak;
  logic [15:0] width_ms, interval_ms, pass_count;
  logic        wr_en;
  reg_idx_t    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline    <= 8'd40;
      peak        <= 8'd200;
      width_ms    <= 16'd40;
      interval_ms <= 16'd5000;
      pass_count  <= 16'd10;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_BASELINE: baseline    <= pwdata[7:0];
        REG_PEAK:     peak        <= pwdata[7:0];
        REG_WIDTH:    width_ms    <= pwdata[15:0];
        REG_INTERVAL: interval_ms <= pwdata[15:0];
        REG_COUNT:    pass_count  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (wr_idx)
      REG_BASELINE: prdata = {24'd0, baseline};
      REG_PEAK:     prdata = {24'd0, peak};
      REG_WIDTH:    prdata = {16'd0, width_ms};
      REG_INTERVAL: prdata = {16'd0, interval_ms};
      REG_COUNT:    prdata = {16'd0, pass_count};
      default:      prdata = '0;
    endcase
  end

  // run and marker state
  logic              run_flag, in_pass_flag, edge_pending;
  logic [TICK_W-1:0] tick_counter, pass_ticks, cycle_ticks;
  logic [15:0]       pass_counter, drop_counter;
  logic [31:0]       pass_start_time, edge_time, edge_start_time, last_edge_time;
  logic [7:0]        running_max, latched_max;

  logic              run_flag_next, in_pass_flag_next, edge_pending_next;
  logic [TICK_W-1:0] tick_counter_next, pass_ticks_next, cycle_ticks_next;
  logic [15:0]       pass_counter_next, drop_counter_next;
  logic [31:0]       pass_start_time_next, edge_time_next, edge_start_time_next;
  logic [31:0]       last_edge_time_next;
  logic [7:0]        running_max_next, latched_max_next;

  state_t state, state_next;
  logic   accept, deliver;
  logic   env_go;
  logic   load_now;

  assign accept  = in_valid && in_ready;
  assign deliver = out_valid && out_ready;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  // immediate result values
  logic [7:0]  r_dac;
  logic        r_driven, r_ended, r_ready;
  logic [31:0] r_mstart, r_lat;

  // tick, pass count and edge gap math
  logic [TICK_W-1:0] p_ticks, c_ticks, tc_inc;
  logic [31:0]       edge_gap;
  logic [15:0]       pc_inc;
  opcode_t           op;

  assign op = opcode_t'(opcode);

  always_comb begin
    p_ticks = TICK_W'({width_ms, 3'b000}) + TICK_W'({width_ms, 1'b0});
    c_ticks = TICK_W'({interval_ms, 3'b000}) + TICK_W'({interval_ms, 1'b0});
    if (p_ticks == '0) p_ticks = TICK_W'(1);
    if (p_ticks > TICK_MAX - 1'b1) p_ticks = TICK_MAX - 1'b1;
    if (c_ticks <= p_ticks) c_ticks = p_ticks + 1'b1;
    tc_inc   = tick_counter + 1'b1;
    edge_gap = now_us - last_edge_time;
    pc_inc   = (pass_counter != 16'hFFFF) ? pass_counter + 1'b1 : pass_counter;
  end

  // item decode and next state
  always_comb begin
    run_flag_next        = run_flag;
    in_pass_flag_next    = in_pass_flag;
    edge_pending_next    = edge_pending;
    tick_counter_next    = tick_counter;
    pass_ticks_next      = pass_ticks;
    cycle_ticks_next     = cycle_ticks;
    pass_counter_next    = pass_counter;
    drop_counter_next    = drop_counter;
    pass_start_time_next = pass_start_time;
    edge_time_next       = edge_time;
    edge_start_time_next = edge_start_time;
    last_edge_time_next  = last_edge_time;
    running_max_next     = running_max;
    latched_max_next     = latched_max;
    r_dac    = '0;
    r_driven = 1'b0;
    r_ended  = 1'b0;
    r_ready  = 1'b0;
    r_mstart = '0;
    r_lat    = '0;
    env_go   = 1'b0;
    case (op)
      OP_TICK: begin
        if (run_flag) begin
          tick_counter_next = tc_inc;
          if (!in_pass_flag) begin
            if (tc_inc >= cycle_ticks) begin
              tick_counter_next    = '0;
              in_pass_flag_next    = 1'b1;
              running_max_next     = '0;
              pass_start_time_next = now_us;
            end else begin
              r_dac    = baseline;
              r_driven = 1'b1;
            end
          end else if (tick_counter >= pass_ticks) begin
            r_ended           = 1'b1;
            in_pass_flag_next = 1'b0;
            latched_max_next  = running_max;
            pass_counter_next = pc_inc;
            if (pc_inc >= pass_count) run_flag_next = 1'b0;
            r_dac    = baseline;
            r_driven = 1'b1;
          end else begin
            env_go = 1'b1;
          end
        end
      end
      OP_START: begin
        pass_ticks_next   = p_ticks;
        cycle_ticks_next  = c_ticks;
        pass_counter_next = '0;
        tick_counter_next = '0;
        in_pass_flag_next = 1'b0;
        edge_pending_next = 1'b0;
        drop_counter_next = '0;
        run_flag_next     = 1'b1;
      end
      OP_STOP: begin
        run_flag_next = 1'b0;
        r_dac    = baseline;
        r_driven = 1'b1;
      end
      OP_LEVEL: begin
        run_flag_next = 1'b0;
        r_dac    = level_value;
        r_driven = 1'b1;
      end
      OP_EDGE: begin
        if (edge_gap >= MIN_EDGE_GAP) begin
          last_edge_time_next = now_us;
          if (edge_pending) begin
            if (drop_counter != 16'hFFFF) drop_counter_next = drop_counter + 1'b1;
          end else begin
            edge_time_next       = now_us;
            edge_start_time_next = pass_start_time;
            edge_pending_next    = 1'b1;
          end
        end
      end
      OP_DRAIN: begin
        if (edge_pending) begin
          r_ready           = 1'b1;
          r_mstart          = edge_start_time;
          r_lat             = edge_time - edge_start_time;
          edge_pending_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // envelope datapath: index divider, rom, multiply
  logic [IDX_W-1:0]  quo;
  logic              div_done;
  logic              env_start;
  logic [TICK_W-1:0] env_t;
  logic [DVD_W-1:0]  dvd;
  logic [IDX_W-1:0]  idx;
  logic [HIDX_W-1:0] rom_addr;
  logic [15:0]       weight;
  logic signed [25:0] prod;
  logic signed [8:0]  span;
  logic signed [26:0] rnd;
  logic signed [11:0] lvl_s;
  logic [7:0]         env_dac;

  assign dvd = (DVD_W'(env_t) << IDX_W) - DVD_W'(env_t);

  peg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (env_start),
    .dividend (dvd),
    .divisor  (pass_ticks),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (accept && env_go) env_t <= tick_counter;
    if (div_done) idx <= quo;
  end

  assign rom_addr = (idx < IDX_W'(HALF_DEPTH)) ? idx[HIDX_W-1:0]
                                               : HIDX_W'(TABLE_LAST - idx);

  peg_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (weight)
  );

  assign span = $signed({1'b0, peak}) - $signed({1'b0, baseline});

  always_ff @(posedge clk) begin
    if (state == ST_MUL) prod <= span * $signed({1'b0, weight});
  end

  // round, floor shift and clamp
  always_comb begin
    rnd   = 27'(prod) + 27'sd32768;
    lvl_s = $signed({4'd0, baseline}) + 12'(rnd >>> 16);
    if (lvl_s < 0) env_dac = 8'd0;
    else if (lvl_s > 12'sd255) env_dac = 8'd255;
    else env_dac = lvl_s[7:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      env_start <= 1'b0;
    end else begin
      state     <= state_next;
      env_start <= accept && env_go;
    end
  end

  always_comb begin
    state_next = state;
    load_now   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (env_go) state_next = ST_DIV;
          else load_now = 1'b1;
        end
      end
      ST_DIV: if (div_done) state_next = ST_ROM;
      ST_ROM: state_next = ST_MUL;
      ST_MUL: state_next = ST_FIN;
      ST_FIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag        <= 1'b0;
      in_pass_flag    <= 1'b0;
      edge_pending    <= 1'b0;
      tick_counter    <= '0;
      pass_ticks      <= '0;
      cycle_ticks     <= '0;
      pass_counter    <= '0;
      drop_counter    <= '0;
      pass_start_time <= '0;
      edge_time       <= '0;
      edge_start_time <= '0;
      last_edge_time  <= '0;
      running_max     <= '0;
      latched_max     <= '0;
    end else if (accept) begin
      run_flag        <= run_flag_next;
      in_pass_flag    <= in_pass_flag_next;
      edge_pending    <= edge_pending_next;
      tick_counter    <= tick_counter_next;
      pass_ticks      <= pass_ticks_next;
      cycle_ticks     <= cycle_ticks_next;
      pass_counter    <= pass_counter_next;
      drop_counter    <= drop_counter_next;
      pass_start_time <= pass_start_time_next;
      edge_time       <= edge_time_next;
      edge_start_time <= edge_start_time_next;
      last_edge_time  <= last_edge_time_next;
      running_max     <= running_max_next;
      latched_max     <= latched_max_next;
    end else if (state == ST_FIN && env_dac > running_max) begin
      running_max <= env_dac;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || state == ST_FIN) begin
      out_valid <= 1'b1;
    end else if (deliver) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      dac_value       <= r_dac;
      dac_driven      <= r_driven;
      run_active      <= run_flag_next;
      passes_done     <= pass_counter_next;
      pass_ended      <= r_ended;
      pass_peak       <= latched_max_next;
      marker_ready    <= r_ready;
      marker_start_us <= r_mstart;
      latency_us      <= r_lat;
      dropped_edges   <= drop_counter_next;
      run_done        <= run_flag && !run_flag_next;
    end else if (state == ST_FIN) begin
      dac_value       <= env_dac;
      dac_driven      <= 1'b1;
      run_active      <= run_flag;
      passes_done     <= pass_counter;
      pass_ended      <= 1'b0;
      pass_peak       <= latched_max;
      marker_ready    <= 1'b0;
      marker_start_us <= '0;
      latency_us      <= '0;
      dropped_edges   <= drop_counter;
      run_done        <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // no new transfer while the envelope path is busy
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input ready while sequencer busy");

  // divider only finishes while the sequencer waits on it
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide state");

  // undriven results carry a zero level
  a_dac_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dac_driven |-> dac_value == 8'd0)
    else $error("level nonzero on undriven result");

  // marker fields are zero without a measurement
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !marker_ready |-> latency_us == 32'd0 && marker_start_us == 32'd0)
    else $error("marker fields set without measurement");
`endif

endmodule
`default_nettype wire

/* design/peg_div.sv */
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module peg_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [peg_pkg::DVD_W-1:0]  dividend,
  input  wire logic [peg_pkg::TICK_W-1:0] divisor,
  output logic                            done,
  output logic [peg_pkg::IDX_W-1:0]       quotient
);
  import peg_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [TICK_W:0]  rem;
  logic [DVD_W-1:0] quo;
  logic [TICK_W:0]  shifted;
  logic [TICK_W:0]  diff;
  logic             fits;

  // shift in next dividend bit and trial subtract
  always_comb begin
    shifted = {rem[TICK_W-1:0], quo[DVD_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff : shifted;
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo[IDX_W-1:0];

endmodule
`default_nettype wire

/* design/peg_rom.sv */
// half-wave weight rom with registered read
`default_nettype none
module peg_rom (
  input  wire logic                       clk,
  input  wire logic [peg_pkg::HIDX_W-1:0] addr,
  output logic [15:0]                     data
);
  import peg_pkg::*;

  logic [15:0] rom [HALF_DEPTH];

  for (genvar g = 0; g < HALF_DEPTH; g++) begin : g_rom
    assign rom[g] = weight_of(g);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule
`default_nettype wire
